[design/hed_pkg.sv]
// ---------------------------------------------------------------------------
// hed_pkg: shared types and constants of the hex escape decoder
// Character codes, decode helpers and the job word passed front to back.
// ---------------------------------------------------------------------------
package hed_pkg;

  localparam int unsigned CNT_W       = 16;   // output byte counter / limit width
  localparam int unsigned MAX_RES     = 4;    // results one input byte can cause
  localparam int unsigned NUM_W       = 3;    // holds 0..MAX_RES
  localparam int unsigned QUEUE_DEPTH = 4;    // default job queue depth

  localparam logic [CNT_W-1:0] OUT_LEN_RESET = 16'd256;

  localparam logic [7:0] CH_BSL = 8'h5C;  // backslash
  localparam logic [7:0] CH_X   = 8'h78;  // 'x'
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_LA  = 8'h61;  // 'a'
  localparam logic [7:0] CH_LF  = 8'h66;  // 'f'
  localparam logic [7:0] CH_LZ  = 8'h7A;  // 'z'
  localparam logic [7:0] CH_UA  = 8'h41;  // 'A'
  localparam logic [7:0] CH_UF  = 8'h46;  // 'F'
  localparam logic [7:0] CH_UZ  = 8'h5A;  // 'Z'

  // One decoded input byte: up to four data bytes plus end-of-string flag.
  // num == 0 with last set is the bare end marker.
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [NUM_W-1:0]        num;
    logic                    last;
  } job_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_LA) && (c <= CH_LZ)) ||
           ((c >= CH_UA) && (c <= CH_UZ));
  endfunction

  function automatic logic [3:0] nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if ((c >= CH_0) && (c <= CH_9)) begin
      v = c - CH_0;
    end else if ((c >= CH_LA) && (c <= CH_LF)) begin
      v = c - CH_LA + 8'd10;
    end else if ((c >= CH_UA) && (c <= CH_UF)) begin
      v = c - CH_UA + 8'd10;
    end
    return v[3:0];
  endfunction

endpackage

[design/hex_escape_decoder_unit.sv]
// ---------------------------------------------------------------------------
// hex_escape_decoder_unit: backslash-x hex escape decoder, top level
// Path: an accepted word is written into the queue and then loaded into
// the back's job register, from which its first result leaves.
// Throughput: one input byte per cycle while the queue is not full; results
// leave at one per cycle while out_ready_i is high, up to 4 per input byte.
// Reset: async active low; no partial escape, zero count, limit 256.
// ---------------------------------------------------------------------------
// Structure:
//   front  - classifies each byte against the held escape state, applies
//            the per-string output limit and builds a job word of up to
//            four result bytes (or a bare end marker).
//   queue  - a few job words deep, so input and output stall independently.
//   back   - registered job plus index; steps through the job's results.
// A byte that yields no result (escape still pending, or limit reached on
// a non-final byte) never enters the queue.
module hex_escape_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = hed_pkg::QUEUE_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration: max output bytes per string
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [hed_pkg::CNT_W-1:0] cfg_max_out_len_i,
  // input word
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                in_byte_i,
  input  logic                      in_last_i,
  // output word
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                out_byte_o,
  output logic                      byte_valid_o,
  output logic                      run_last_o,
  output logic                      string_end_o
);
  import hed_pkg::*;

  job_t push_job, head_job;
  logic push, q_full, q_empty, pop;

  // limit register takes a write in any cycle
  assign cfg_ready_o = 1'b1;

  hed_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_max_out_len_i (cfg_max_out_len_i),
    .in_valid_i        (in_valid_i),
    .in_byte_i         (in_byte_i),
    .in_last_i         (in_last_i),
    .q_full_i          (q_full),
    .in_ready_o        (in_ready_o),
    .push_o            (push),
    .job_o             (push_job)
  );

  hed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (head_job),
    .empty_o     (q_empty)
  );

  hed_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_data_i     (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

endmodule

[design/hed_front.sv]
// ---------------------------------------------------------------------------
// hed_front: input side of the hex escape decoder
// Tracks partial escapes and the per-string output count, and turns each
// accepted byte with a result or string end into a job word of result bytes.
// ---------------------------------------------------------------------------
module hed_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [hed_pkg::CNT_W-1:0] cfg_max_out_len_i,
  input  logic                  in_valid_i,
  input  logic [7:0]            in_byte_i,
  input  logic                  in_last_i,
  input  logic                  q_full_i,
  output logic                  in_ready_o,
  output logic                  push_o,
  output hed_pkg::job_t         job_o
);
  import hed_pkg::*;

  logic [CNT_W-1:0] max_q, cnt_q, cnt_d;
  logic [1:0]       held_q, held_d;
  logic [7:0]       digit_q, digit_d;

  logic [MAX_RES-1:0][7:0] cand;
  logic [NUM_W-1:0]        n;
  logic [NUM_W-1:0]        k;
  logic [CNT_W:0]          rem;
  logic                    fail, afresh, accept;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    cand    = '0;
    n       = '0;
    held_d  = held_q;
    digit_d = digit_q;
    fail    = 1'b0;
    afresh  = 1'b0;
    rem     = '0;
    unique case (held_q)
      2'd0: afresh = 1'b1;
      2'd1: begin
        if (in_byte_i == CH_X) held_d = 2'd2;
        else fail = 1'b1;
      end
      2'd2: begin
        if (is_alnum(in_byte_i)) begin
          held_d  = 2'd3;
          digit_d = in_byte_i;
        end else begin
          fail = 1'b1;
        end
      end
      default: begin
        if (is_alnum(in_byte_i)) begin
          held_d  = 2'd0;
          cand[n[1:0]] = {nibble(digit_q), nibble(in_byte_i)};
          n = n + 3'd1;
        end else begin
          fail = 1'b1;
        end
      end
    endcase
    // failed escape: held bytes go out literally, byte is looked at again
    if (fail) begin
      cand[n[1:0]] = CH_BSL;
      n = n + 3'd1;
      if (held_q >= 2'd2) begin
        cand[n[1:0]] = CH_X;
        n = n + 3'd1;
      end
      if (held_q == 2'd3) begin
        cand[n[1:0]] = digit_q;
        n = n + 3'd1;
      end
      afresh = 1'b1;
    end
    if (afresh) begin
      if (in_byte_i == CH_BSL) begin
        held_d = 2'd1;
      end else begin
        held_d = 2'd0;
        cand[n[1:0]] = in_byte_i;
        n = n + 3'd1;
      end
    end
    // end of string flushes whatever is still held
    if (in_last_i) begin
      if (held_d >= 2'd1) begin
        cand[n[1:0]] = CH_BSL;
        n = n + 3'd1;
      end
      if (held_d >= 2'd2) begin
        cand[n[1:0]] = CH_X;
        n = n + 3'd1;
      end
      if (held_d == 2'd3) begin
        cand[n[1:0]] = digit_d;
        n = n + 3'd1;
      end
      held_d  = 2'd0;
      digit_d = 8'd0;
    end
    // output limit: only the first (max - count) bytes survive
    if (cnt_q >= max_q) begin
      k = '0;
    end else begin
      rem = {1'b0, max_q} - {1'b0, cnt_q};
      k   = (rem > {{(CNT_W+1-NUM_W){1'b0}}, n}) ? n : rem[NUM_W-1:0];
    end
    cnt_d = in_last_i ? '0 : cnt_q + {{(CNT_W-NUM_W){1'b0}}, k};
  end

  assign job_o.bytes = cand;
  assign job_o.num   = k;
  assign job_o.last  = in_last_i;
  // a byte that causes no result leaves nothing in the queue
  assign push_o      = accept & ((k != '0) | in_last_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= OUT_LEN_RESET;
      cnt_q   <= '0;
      held_q  <= 2'd0;
      digit_q <= 8'd0;
    end else begin
      if (cfg_valid_i) max_q <= cfg_max_out_len_i;
      if (accept) begin
        cnt_q   <= cnt_d;
        held_q  <= held_d;
        digit_q <= digit_d;
      end
    end
  end

endmodule

[design/hed_queue.sv]
// ---------------------------------------------------------------------------
// hed_queue: job queue between front and back
// Small circular buffer of job words; full and empty come from registers.
// ---------------------------------------------------------------------------
module hed_queue #(
  parameter int unsigned DEPTH = hed_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hed_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output hed_pkg::job_t pop_data_o,
  output logic          empty_o
);
  import hed_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o     = (cnt_q == CW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      if (do_pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
    end
  end

endmodule

[design/hed_back.sv]
// ---------------------------------------------------------------------------
// hed_back: output serializer of the hex escape decoder
// Holds one job word and hands out its results one per output handshake.
// ---------------------------------------------------------------------------
module hed_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  hed_pkg::job_t q_data_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          byte_valid_o,
  output logic          run_last_o,
  output logic          string_end_o
);
  import hed_pkg::*;

  job_t       job_q;
  logic       job_v_q;
  logic [1:0] idx_q;
  logic       bare, at_end, done, load;

  assign bare   = (job_q.num == '0);
  assign at_end = bare | ({1'b0, idx_q} == (job_q.num - 3'd1));
  assign done   = job_v_q & out_ready_i & at_end;
  assign load   = ~job_v_q | done;
  assign pop_o  = load & ~q_empty_i;

  assign out_valid_o  = job_v_q;
  assign out_byte_o   = bare ? 8'd0 : job_q.bytes[idx_q];
  assign byte_valid_o = ~bare;
  assign run_last_o   = at_end;
  assign string_end_o = at_end & job_q.last;

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= q_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_v_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (load) begin
        job_v_q <= ~q_empty_i;
        idx_q   <= 2'd0;
      end else if (out_ready_i) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

endmodule
